// ----- src/i2cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbe_pkg
// shared types, widths and codes of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  // field widths
  localparam int MODE_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 7;
  localparam int HP_W       = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // bits in one byte slot, msb first
  localparam int BYTE_BITS = 8;

  // default number of recovery clock pulses
  localparam int RECOVERY_CLOCKS_DEF = 9;

  // reset value of the half period register
  localparam logic [HP_W-1:0] HALF_PERIOD_RST = 16'd250;

  // command codes
  localparam logic [MODE_W-1:0] MODE_START   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADDRESS = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RECOVER = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NACK = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SKIP = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD    = 2'd1;

  // one bus command
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic              read_not_write;
    logic              master_ack;
    logic              slave_ack_bit;
    logic [BYTE_W-1:0] slave_data;
  } cmd_t;

  // one pin phase
  typedef struct packed {
    logic                scl;
    logic                sda;
    logic                last;
    logic [BYTE_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
  } phase_t;

endpackage

// ----- src/i2cbe_if.sv -----
// ----------------------------------------------------------------------------
// i2cbe_if
// valid/ready channels of the bit engine: commands in, pin phases out
// ----------------------------------------------------------------------------
interface i2cbe_cmd_if
  import i2cbe_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] data_byte;
  logic              read_not_write;
  logic              master_ack;
  logic              slave_ack_bit;
  logic [BYTE_W-1:0] slave_data;

  modport source (
    output valid, mode, data_byte, read_not_write, master_ack, slave_ack_bit, slave_data,
    input  ready
  );
  modport sink (
    input  valid, mode, data_byte, read_not_write, master_ack, slave_ack_bit, slave_data,
    output ready
  );
endinterface

interface i2cbe_phase_if
  import i2cbe_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                scl_level;
  logic                sda_level;
  logic                last_phase;
  logic [BYTE_W-1:0]   read_data;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, scl_level, sda_level, last_phase, read_data, status,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, last_phase, read_data, status,
    output ready
  );
endinterface

// ----- src/i2cbe_timer.sv -----
// ----------------------------------------------------------------------------
// i2cbe_timer
// half period hold counter, restarted on every phase
// ----------------------------------------------------------------------------
module i2cbe_timer
  import i2cbe_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic [HP_W-1:0] ticks_i,
  output logic            done_o
);

  logic [HP_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = ticks_i - HP_W'(1);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - HP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign done_o = (cnt_q == '0);

endmodule

// ----- src/i2cbe_seq.sv -----
// ----------------------------------------------------------------------------
// i2cbe_seq
// phase sequencer: walks the bit slots of a command through a shift register
// ----------------------------------------------------------------------------
module i2cbe_seq
  import i2cbe_pkg::*;
#(
  parameter int RecoveryClocks = RECOVERY_CLOCKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  cmd_t              cmd_i,
  input  logic [ADDR_W-1:0] dev_addr_i,
  input  logic              step_i,
  output logic              busy_o,
  output phase_t            phase_o
);

  localparam int SlotMax = (RecoveryClocks > BYTE_BITS + 1) ? RecoveryClocks : BYTE_BITS + 1;
  localparam int SlotW   = $clog2(SlotMax);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_BYTE  = 3'd2;
  localparam logic [2:0] S_RDBIT = 3'd3;
  localparam logic [2:0] S_RDACK = 3'd4;
  localparam logic [2:0] S_RECOV = 3'd5;
  localparam logic [2:0] S_STOP  = 3'd6;
  localparam logic [2:0] S_SKIP  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [1:0]        sub_q, sub_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [BYTE_W-1:0] tx_q, tx_d;
  logic [BYTE_W-1:0] rx_q, rx_d;
  logic              sack_q, sack_d;
  logic              ack_lvl_q, ack_lvl_d;
  logic              abort_q, abort_d;
  logic              scl_now_q, scl_now_d;
  logic              sda_now_q, sda_now_d;
  phase_t            ph;
  logic              ack_slot;

  assign ack_slot = (slot_q == SlotW'(BYTE_BITS));

  // current phase from state, sub phase and shift register msb
  always_comb begin
    ph        = '0;
    ph.scl    = 1'b1;
    ph.sda    = 1'b1;
    ph.status = STAT_OK;
    case (state_q)
      S_START: begin
        ph.scl  = (sub_q != 2'd2);
        ph.sda  = (sub_q == 2'd0);
        ph.last = (sub_q == 2'd2);
      end
      S_STOP: begin
        ph.scl  = (sub_q == 2'd0) ? scl_now_q : 1'b1;
        ph.sda  = (sub_q == 2'd2);
        ph.last = (sub_q == 2'd2);
      end
      S_BYTE: begin
        ph.scl  = (sub_q == 2'd0) ? scl_now_q : (sub_q == 2'd1);
        ph.sda  = tx_q[BYTE_W-1];
        ph.last = ack_slot && (sub_q == 2'd2);
        if (ph.last && sack_q) begin
          ph.status = STAT_NACK;
        end
      end
      S_RDBIT: begin
        ph.scl = (sub_q == 2'd0);
      end
      S_RDACK: begin
        ph.scl  = (sub_q == 2'd1);
        ph.sda  = ack_lvl_q;
        ph.last = (sub_q == 2'd2);
        if (sub_q == 2'd2) begin
          ph.read_data = rx_q;
        end
      end
      S_RECOV: begin
        ph.scl = (sub_q == 2'd0);
      end
      S_SKIP: begin
        ph.scl    = scl_now_q;
        ph.sda    = sda_now_q;
        ph.last   = 1'b1;
        ph.status = STAT_SKIP;
      end
      default: begin
        ph.scl = scl_now_q;
        ph.sda = sda_now_q;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    sub_d     = sub_q;
    slot_d    = slot_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    sack_d    = sack_q;
    ack_lvl_d = ack_lvl_q;
    abort_d   = abort_q;
    scl_now_d = scl_now_q;
    sda_now_d = sda_now_q;

    if (take_i) begin
      sub_d     = '0;
      slot_d    = '0;
      sack_d    = cmd_i.slave_ack_bit;
      ack_lvl_d = !cmd_i.master_ack;
      // skip only commands that need a healthy transfer
      if (abort_q && (cmd_i.mode inside {MODE_START, MODE_ADDRESS, MODE_WRITE,
                                         MODE_READ})) begin
        state_d = S_SKIP;
      end else begin
        case (cmd_i.mode)
          MODE_START:   state_d = S_START;
          MODE_STOP:    state_d = S_STOP;
          MODE_ADDRESS: begin
            state_d = S_BYTE;
            tx_d    = {dev_addr_i, cmd_i.read_not_write};
          end
          MODE_WRITE: begin
            state_d = S_BYTE;
            tx_d    = cmd_i.data_byte;
          end
          MODE_READ: begin
            state_d = S_RDBIT;
            tx_d    = cmd_i.slave_data;
          end
          MODE_RECOVER: state_d = S_RECOV;
          default:      state_d = S_IDLE;
        endcase
      end
    end else if (step_i && busy_o) begin
      scl_now_d = ph.scl;
      sda_now_d = ph.sda;
      case (state_q)
        S_START: begin
          sub_d = sub_q + 2'd1;
          if (ph.last) state_d = S_IDLE;
        end
        S_STOP: begin
          sub_d = sub_q + 2'd1;
          if (ph.last) begin
            state_d = S_IDLE;
            abort_d = 1'b0;
          end
        end
        S_BYTE: begin
          if (sub_q == 2'd2) begin
            sub_d  = '0;
            slot_d = slot_q + SlotW'(1);
            tx_d   = {tx_q[BYTE_W-2:0], 1'b1};
            if (ack_slot) begin
              state_d = S_IDLE;
              abort_d = abort_q | sack_q;
            end
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
        S_RDBIT: begin
          if (sub_q == 2'd1) begin
            sub_d  = '0;
            slot_d = slot_q + SlotW'(1);
            tx_d   = {tx_q[BYTE_W-2:0], 1'b1};
            rx_d   = {rx_q[BYTE_W-2:0], tx_q[BYTE_W-1]};
            if (slot_q == SlotW'(BYTE_BITS - 1)) begin
              state_d = S_RDACK;
              slot_d  = '0;
            end
          end else begin
            sub_d = 2'd1;
          end
        end
        S_RDACK: begin
          sub_d = sub_q + 2'd1;
          if (ph.last) begin
            state_d   = S_IDLE;
            sda_now_d = 1'b1;  // release sda after the ack slot
          end
        end
        S_RECOV: begin
          if (sub_q == 2'd1) begin
            sub_d  = '0;
            slot_d = slot_q + SlotW'(1);
            if (slot_q == SlotW'(RecoveryClocks - 1)) begin
              state_d = S_STOP;
              slot_d  = '0;
            end
          end else begin
            sub_d = 2'd1;
          end
        end
        S_SKIP:  state_d = S_IDLE;
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sub_q     <= '0;
      slot_q    <= '0;
      abort_q   <= 1'b0;
      scl_now_q <= 1'b1;
      sda_now_q <= 1'b1;
    end else begin
      state_q   <= state_d;
      sub_q     <= sub_d;
      slot_q    <= slot_d;
      abort_q   <= abort_d;
      scl_now_q <= scl_now_d;
      sda_now_q <= sda_now_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_q      <= tx_d;
    rx_q      <= rx_d;
    sack_q    <= sack_d;
    ack_lvl_q <= ack_lvl_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign phase_o = ph;

endmodule

// ----- src/i2c_master_bit_engine.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// i2c master bit engine: turns bus commands into held (scl, sda) pin phases
// ----------------------------------------------------------------------------
//
//  channel   dir  port      one transfer carries
//  --------  ---  --------  -------------------------------------------------
//  command   in   cmd_i     mode, data byte, r/w bit, master ack, slave bits
//  phase     out  phase_o   scl, sda, last phase flag, read byte, status
//  config    in   cfg_*_i   device address (0), half period ticks (1)
//
//  each phase is held by the hold counter, which is loaded from the half
//  period register, so the time a command takes scales with its number of
//  phases: start and stop 3 phases, address and write byte 27, read byte 19,
//  recovery 2*RecoveryClocks+3, a skipped command 1
//  one command is in work at a time; the next is taken once the last phase
//  of the current one sits in the output register
//  a stalled phase output holds the sequencer; the hold counter keeps running
//  rst_ni clears the sequencer, abort flag, line levels and output valid
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
  import i2cbe_pkg::*;
#(
  parameter int RecoveryClocks = RECOVERY_CLOCKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  i2cbe_cmd_if.sink             cmd_i,
  i2cbe_phase_if.source         phase_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // configuration registers
  logic [ADDR_W-1:0] dev_addr_q;
  logic [HP_W-1:0]   half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
      half_q     <= HALF_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEVICE_ADDRESS: dev_addr_q <= cfg_wdata_i[ADDR_W-1:0];
        REG_HALF_PERIOD:    half_q     <= cfg_wdata_i[HP_W-1:0];
        default:            ;  // unmapped index, write dropped
      endcase
    end
  end

  // command transfer into the sequencer
  cmd_t   cmd;
  logic   cmd_take;
  logic   seq_busy;
  phase_t seq_phase;
  logic   step;
  logic   timer_done;

  assign cmd.mode           = cmd_i.mode;
  assign cmd.data_byte      = cmd_i.data_byte;
  assign cmd.read_not_write = cmd_i.read_not_write;
  assign cmd.master_ack     = cmd_i.master_ack;
  assign cmd.slave_ack_bit  = cmd_i.slave_ack_bit;
  assign cmd.slave_data     = cmd_i.slave_data;

  assign cmd_i.ready = !seq_busy;
  assign cmd_take    = cmd_i.valid && cmd_i.ready;

  i2cbe_seq #(
    .RecoveryClocks(RecoveryClocks)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (cmd_take),
    .cmd_i     (cmd),
    .dev_addr_i(dev_addr_q),
    .step_i    (step),
    .busy_o    (seq_busy),
    .phase_o   (seq_phase)
  );

  // a new phase goes out once the previous one has been held long enough and
  // the output register is free or being emptied this cycle
  logic   out_valid_q;
  phase_t out_q;
  logic   out_free;

  assign out_free = !out_valid_q || phase_o.ready;
  assign step     = seq_busy && timer_done && out_free;

  i2cbe_timer u_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step),
    .ticks_i(half_q),
    .done_o (timer_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (phase_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= seq_phase;
    end
  end

  assign phase_o.valid      = out_valid_q;
  assign phase_o.scl_level  = out_q.scl;
  assign phase_o.sda_level  = out_q.sda;
  assign phase_o.last_phase = out_q.last;
  assign phase_o.read_data  = out_q.read_data;
  assign phase_o.status     = out_q.status;

`ifndef SYNTH
  // the sequencer goes idle right after handing out a last phase
  a_last_ends_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && seq_phase.last |=> !seq_busy)
    else $error("sequencer still busy after last phase");

  // the hold counter is still counting after a phase is loaded, unless the period is one tick
  a_hold_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (half_q != HP_W'(1)) |=> !timer_done)
    else $error("hold counter did not start on a new phase");

  // status other than ok only on a last phase
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != STAT_OK) |-> out_q.last)
    else $error("status reported before the last phase");

  // read byte shows up only on a last phase
  a_rdata_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.read_data != '0) |-> out_q.last)
    else $error("read data reported before the last phase");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench of the i2c master bit engine: a directed table, then
// random well-formed bus transactions mixed with noise, under several
// register settings; every pin phase is compared with an in-bench predictor
// ----------------------------------------------------------------------------
module tb_top;
  import i2cbe_pkg::*;

  // mode codes the engine must ignore
  localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

  // register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int          RESET_CYCLES   = 11;
  localparam int          HOLDOFF_CYCLES = 600;
  localparam int          MAX_REPORTS    = 200;
  localparam int unsigned CYCLE_LIMIT    = 2_500_000;

  // one row of the directed table; a pinned row carries its last phase typed in
  typedef struct {
    cmd_t   cmd;
    bit     pinned;
    phase_t last_exp;
  } dir_row_t;

  typedef struct {
    bit     pinned;
    phase_t last_exp;
  } pin_note_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  i2cbe_cmd_if   cmd_bus ();
  i2cbe_phase_if phase_bus ();

  i2c_master_bit_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_bus),
    .phase_o     (phase_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state: line levels last driven, abort flag, registers
  bit              line_scl;
  bit              line_sda;
  bit              bus_aborted;
  logic [ADDR_W-1:0] target_addr;
  logic [HP_W-1:0]   hp_now;

  phase_t    expected_phases[$];
  pin_note_t pin_q[$];
  dir_row_t  dir_tab[$];

  int          err_count;
  int          phase_count;
  int          burst_left;
  int          rand_items_sent;
  bit          holdoff_req;
  int unsigned cycle_count;

  // 4 ns clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a lost phase ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // one held phase; the lines keep its levels afterwards
  function automatic void put_phase(bit s, bit d);
    phase_t p;
    p = '0;
    p.scl = s;
    p.sda = d;
    expected_phases.push_back(p);
    line_scl = s;
    line_sda = d;
  endfunction

  // mark the last phase of a command and attach its status and read byte
  function automatic void close_cmd(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] rd);
    phase_t p;
    p = expected_phases.pop_back();
    p.last      = 1'b1;
    p.read_data = rd;
    p.status    = st;
    expected_phases.push_back(p);
  endfunction

  // stop condition; the first phase keeps the clock where it is
  function automatic void stop_phases();
    put_phase(line_scl, 1'b0);
    put_phase(1'b1, 1'b0);
    put_phase(1'b1, 1'b1);
  endfunction

  // eight data bits msb first, then the ack slot with sda released
  function automatic void write_byte_phases(logic [BYTE_W-1:0] b, bit nack);
    int i;
    for (i = BYTE_BITS - 1; i >= 0; i--) begin
      put_phase(line_scl, b[i]);
      put_phase(1'b1, b[i]);
      put_phase(1'b0, b[i]);
    end
    put_phase(line_scl, 1'b1);
    put_phase(1'b1, 1'b1);
    put_phase(1'b0, 1'b1);
    if (nack) begin
      bus_aborted = 1'b1;
      close_cmd(STAT_NACK, '0);
    end else begin
      close_cmd(STAT_OK, '0);
    end
  endfunction

  function automatic void predict_phases(cmd_t c);
    phase_t p;
    bit     ack_lvl;
    int     i;
    if (c.mode > MODE_RECOVER) return;
    // after a nack only stop and recovery run; the rest show one held phase
    if (bus_aborted && c.mode != MODE_STOP && c.mode != MODE_RECOVER) begin
      p = '0;
      p.scl    = line_scl;
      p.sda    = line_sda;
      p.last   = 1'b1;
      p.status = STAT_SKIP;
      expected_phases.push_back(p);
      return;
    end
    case (c.mode)
      MODE_START: begin
        put_phase(1'b1, 1'b1);
        put_phase(1'b1, 1'b0);
        put_phase(1'b0, 1'b0);
        close_cmd(STAT_OK, '0);
      end
      MODE_STOP: begin
        stop_phases();
        close_cmd(STAT_OK, '0);
        bus_aborted = 1'b0;
      end
      MODE_ADDRESS: write_byte_phases({target_addr, c.read_not_write}, c.slave_ack_bit);
      MODE_WRITE:   write_byte_phases(c.data_byte, c.slave_ack_bit);
      MODE_READ: begin
        ack_lvl = ~c.master_ack;
        for (i = 0; i < BYTE_BITS; i++) begin
          put_phase(1'b1, 1'b1);
          put_phase(1'b0, 1'b1);
        end
        put_phase(1'b0, ack_lvl);
        put_phase(1'b1, ack_lvl);
        put_phase(1'b0, ack_lvl);
        close_cmd(STAT_OK, c.slave_data);
        // sda is let go right after the ack slot
        line_sda = 1'b1;
      end
      default: begin
        for (i = 0; i < RECOVERY_CLOCKS_DEF; i++) begin
          put_phase(1'b1, 1'b1);
          put_phase(1'b0, 1'b1);
        end
        stop_phases();
        close_cmd(STAT_OK, '0);
        bus_aborted = 1'b0;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // monitor: predict on each command transfer, check each phase transfer
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    cmd_t      c;
    phase_t    got;
    phase_t    want;
    pin_note_t note;
    if (rst_ni) begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        c = '{mode: cmd_bus.mode, data_byte: cmd_bus.data_byte,
              read_not_write: cmd_bus.read_not_write, master_ack: cmd_bus.master_ack,
              slave_ack_bit: cmd_bus.slave_ack_bit, slave_data: cmd_bus.slave_data};
        note = '{pinned: 1'b0, last_exp: '0};
        if (pin_q.size() != 0) note = pin_q.pop_front();
        predict_phases(c);
        // typed-in last phase of a directed row stands in for the predicted one
        if (note.pinned && c.mode <= MODE_RECOVER) begin
          void'(expected_phases.pop_back());
          expected_phases.push_back(note.last_exp);
        end
      end
      if (phase_bus.valid && phase_bus.ready) begin
        got = '{scl: phase_bus.scl_level, sda: phase_bus.sda_level,
                last: phase_bus.last_phase, read_data: phase_bus.read_data,
                status: phase_bus.status};
        if (expected_phases.size() == 0) begin
          report($sformatf("phase %0d arrived with nothing expected", phase_count));
        end else begin
          want = expected_phases.pop_front();
          if (got.scl !== want.scl)
            report($sformatf("phase %0d scl %0b, want %0b", phase_count, got.scl, want.scl));
          if (got.sda !== want.sda)
            report($sformatf("phase %0d sda %0b, want %0b", phase_count, got.sda, want.sda));
          if (got.last !== want.last)
            report($sformatf("phase %0d last %0b, want %0b", phase_count, got.last, want.last));
          if (got.read_data !== want.read_data)
            report($sformatf("phase %0d read_data %02h, want %02h", phase_count,
                             got.read_data, want.read_data));
          if (got.status !== want.status)
            report($sformatf("phase %0d status %0d, want %0d", phase_count,
                             got.status, want.status));
        end
        phase_count++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: segments of random stall density, plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin : receiver
    int seg_len;
    int seg_kind;
    int k;
    phase_bus.ready = 1'b0;
    while (!rst_ni) @(negedge clk_i);
    forever begin
      seg_len  = $urandom_range(1, 48);
      seg_kind = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(negedge clk_i);
        if (holdoff_req) begin
          // long stall so the engine backs up into the command channel
          phase_bus.ready <= 1'b0;
          for (k = 0; k < HOLDOFF_CYCLES; k++) @(negedge clk_i);
          holdoff_req = 1'b0;
        end
        case (seg_kind)
          0:       phase_bus.ready <= 1'b1;
          1:       phase_bus.ready <= 1'($urandom_range(0, 1));
          2:       phase_bus.ready <= ($urandom_range(0, 3) == 0);
          default: phase_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // offer one command in bursts with random gaps; returns after its transfer
  task automatic drive_cmd(cmd_t c, bit pinned, phase_t last_exp);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    pin_q.push_back('{pinned: pinned, last_exp: last_exp});
    cmd_bus.mode           <= c.mode;
    cmd_bus.data_byte      <= c.data_byte;
    cmd_bus.read_not_write <= c.read_not_write;
    cmd_bus.master_ack     <= c.master_ack;
    cmd_bus.slave_ack_bit  <= c.slave_ack_bit;
    cmd_bus.slave_data     <= c.slave_data;
    cmd_bus.valid          <= 1'b1;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  task automatic sender_idle();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
  endtask

  // slave nacks are rare in well-formed traffic so sequences run deep
  function automatic cmd_t random_cmd(logic [MODE_W-1:0] m, bit noisy);
    cmd_t c;
    c.mode           = m;
    c.data_byte      = BYTE_W'($urandom);
    c.read_not_write = 1'($urandom_range(0, 1));
    c.master_ack     = 1'($urandom_range(0, 1));
    c.slave_ack_bit  = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
    c.slave_data     = BYTE_W'($urandom);
    return c;
  endfunction

  task automatic send_random(logic [MODE_W-1:0] m, bit noisy);
    drive_cmd(random_cmd(m, noisy), 1'b0, '0);
    if (m <= MODE_RECOVER) rand_items_sent++;
  endtask

  task automatic send_data_op();
    send_random(($urandom_range(0, 1) != 0) ? MODE_WRITE : MODE_READ, 1'b0);
  endtask

  // mostly start, address, data, stop; one in five is a loose random command
  task automatic run_random(int n);
    int ops;
    rand_items_sent = 0;
    while (rand_items_sent < n) begin
      if ($urandom_range(0, 4) == 0) begin
        send_random(MODE_W'($urandom_range(0, 7)), 1'b1);
      end else begin
        send_random(MODE_START, 1'b0);
        send_random(MODE_ADDRESS, 1'b0);
        ops = $urandom_range(1, 4);
        repeat (ops) send_data_op();
        if ($urandom_range(0, 3) == 0) begin
          // repeated start
          send_random(MODE_START, 1'b0);
          send_random(MODE_ADDRESS, 1'b0);
          send_data_op();
        end
        send_random(($urandom_range(0, 5) == 0) ? MODE_RECOVER : MODE_STOP, 1'b0);
      end
    end
  endtask

  // all phases out, then one more hold time so an ignored command is done too
  task automatic wait_quiet();
    sender_idle();
    while (expected_phases.size() != 0) @(posedge clk_i);
    repeat (int'(hp_now) + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_DEVICE_ADDRESS) target_addr = data[ADDR_W-1:0];
    if (idx == REG_HALF_PERIOD) hp_now = data[HP_W-1:0];
  endtask

  function automatic dir_row_t dir_row(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] db,
                                       bit rnw, bit mack, bit sack, logic [BYTE_W-1:0] sd,
                                       bit pinned, phase_t last_exp);
    dir_row_t r;
    r.cmd      = '{mode: m, data_byte: db, read_not_write: rnw, master_ack: mack,
                   slave_ack_bit: sack, slave_data: sd};
    r.pinned   = pinned;
    r.last_exp = last_exp;
    return r;
  endfunction

  // last phase of a command, typed in
  function automatic phase_t last_ph(bit s, bit d, logic [BYTE_W-1:0] rd,
                                     logic [STATUS_W-1:0] st);
    return '{scl: s, sda: d, last: 1'b1, read_data: rd, status: st};
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int i;
    rst_ni                 = 1'b0;
    cmd_bus.valid          = 1'b0;
    cmd_bus.mode           = MODE_START;
    cmd_bus.data_byte      = '0;
    cmd_bus.read_not_write = 1'b0;
    cmd_bus.master_ack     = 1'b0;
    cmd_bus.slave_ack_bit  = 1'b0;
    cmd_bus.slave_data     = '0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = REG_DEVICE_ADDRESS;
    cfg_wdata_i            = '0;
    err_count              = 0;
    phase_count            = 0;
    burst_left             = 0;
    holdoff_req            = 1'b0;
    cycle_count            = 0;

    // predictor starts from the reset state
    line_scl    = 1'b1;
    line_sda    = 1'b1;
    bus_aborted = 1'b0;
    target_addr = '0;
    hp_now      = HALF_PERIOD_RST;

    // directed table, run at the reset register values
    dir_tab.push_back(dir_row(MODE_START,   8'h00, 0, 0, 0, 8'h00, 1,
                              last_ph(0, 0, 8'h00, STAT_OK)));
    dir_tab.push_back(dir_row(MODE_ADDRESS, 8'h00, 0, 0, 0, 8'h00, 0, '0));
    dir_tab.push_back(dir_row(MODE_WRITE,   8'hFF, 0, 0, 0, 8'h00, 0, '0));
    dir_tab.push_back(dir_row(MODE_WRITE,   8'h00, 1, 1, 0, 8'hFF, 0, '0));
    dir_tab.push_back(dir_row(MODE_READ,    8'h00, 0, 1, 0, 8'hFF, 1,
                              last_ph(0, 0, 8'hFF, STAT_OK)));
    dir_tab.push_back(dir_row(MODE_READ,    8'hFF, 1, 0, 1, 8'h00, 1,
                              last_ph(0, 1, 8'h00, STAT_OK)));
    dir_tab.push_back(dir_row(MODE_READ,    8'h00, 0, 1, 0, 8'hA5, 0, '0));
    // a nack in the ack slot raises the abort flag
    dir_tab.push_back(dir_row(MODE_WRITE,   8'h5A, 0, 0, 1, 8'h00, 1,
                              last_ph(0, 1, 8'h00, STAT_NACK)));
    // while aborted these hold the present levels for one phase
    dir_tab.push_back(dir_row(MODE_START,   8'h00, 0, 0, 0, 8'h00, 1,
                              last_ph(0, 1, 8'h00, STAT_SKIP)));
    dir_tab.push_back(dir_row(MODE_ADDRESS, 8'h00, 1, 0, 0, 8'h00, 1,
                              last_ph(0, 1, 8'h00, STAT_SKIP)));
    dir_tab.push_back(dir_row(MODE_WRITE,   8'hC3, 0, 0, 1, 8'h00, 1,
                              last_ph(0, 1, 8'h00, STAT_SKIP)));
    dir_tab.push_back(dir_row(MODE_READ,    8'h00, 0, 1, 0, 8'h77, 1,
                              last_ph(0, 1, 8'h00, STAT_SKIP)));
    dir_tab.push_back(dir_row(MODE_UNUSED_6, 8'hFF, 1, 1, 1, 8'hFF, 0, '0));
    // stop clears the abort
    dir_tab.push_back(dir_row(MODE_STOP,    8'h00, 0, 0, 0, 8'h00, 1,
                              last_ph(1, 1, 8'h00, STAT_OK)));
    dir_tab.push_back(dir_row(MODE_START,   8'h00, 0, 0, 0, 8'h00, 1,
                              last_ph(0, 0, 8'h00, STAT_OK)));
    dir_tab.push_back(dir_row(MODE_ADDRESS, 8'h00, 1, 0, 1, 8'h00, 1,
                              last_ph(0, 1, 8'h00, STAT_NACK)));
    // recovery also clears the abort
    dir_tab.push_back(dir_row(MODE_RECOVER, 8'h00, 0, 0, 0, 8'h00, 1,
                              last_ph(1, 1, 8'h00, STAT_OK)));
    dir_tab.push_back(dir_row(MODE_START,   8'h00, 0, 0, 0, 8'h00, 0, '0));
    dir_tab.push_back(dir_row(MODE_ADDRESS, 8'h00, 1, 0, 0, 8'h00, 0, '0));
    // read ending in a master nack, then stop from released sda
    dir_tab.push_back(dir_row(MODE_READ,    8'h00, 0, 0, 0, 8'h3C, 1,
                              last_ph(0, 1, 8'h3C, STAT_OK)));
    dir_tab.push_back(dir_row(MODE_UNUSED_7, 8'h00, 0, 0, 0, 8'h00, 0, '0));
    dir_tab.push_back(dir_row(MODE_STOP,    8'h00, 0, 0, 0, 8'h00, 1,
                              last_ph(1, 1, 8'h00, STAT_OK)));
    // stop and recovery from an idle bus keep the released clock
    dir_tab.push_back(dir_row(MODE_STOP,    8'hFF, 1, 1, 1, 8'hFF, 0, '0));
    dir_tab.push_back(dir_row(MODE_RECOVER, 8'h00, 0, 0, 0, 8'h00, 0, '0));

    // single reset at the start
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < dir_tab.size(); i++)
      drive_cmd(dir_tab[i].cmd, dir_tab[i].pinned, dir_tab[i].last_exp);
    wait_quiet();

    // fastest timing, top address (upper bits masked off); long receiver stall
    write_reg(REG_DEVICE_ADDRESS, 16'hFFFF);
    write_reg(REG_HALF_PERIOD, 16'h0001);
    holdoff_req = 1'b1;
    run_random(15);
    wait_quiet();

    // address zero with junk above bit 6; sender waits for the engine to drain
    write_reg(REG_DEVICE_ADDRESS, 16'hFF80);
    write_reg(REG_HALF_PERIOD, 16'h0002);
    run_random(8);
    sender_idle();
    while (expected_phases.size() != 0) @(posedge clk_i);
    run_random(8);
    wait_quiet();

    // largest half period register value, kept to a short command
    write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'($urandom));
    write_reg(REG_HALF_PERIOD, 16'hFFFF);
    drive_cmd(random_cmd(MODE_START, 1'b0), 1'b0, '0);
    drive_cmd(random_cmd(MODE_UNUSED_6, 1'b1), 1'b0, '0);
    wait_quiet();

    // writes to indexes past the register list must change nothing
    write_reg(REG_SPARE_2, 16'h0001);
    write_reg(REG_SPARE_3, 16'hABCD);
    write_reg(REG_HALF_PERIOD, CFG_DATA_W'($urandom_range(1, 8)));
    write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'($urandom));
    run_random(15);
    wait_quiet();

    write_reg(REG_DEVICE_ADDRESS, CFG_DATA_W'($urandom));
    write_reg(REG_HALF_PERIOD, CFG_DATA_W'($urandom_range(1, 6)));
    run_random(15);
    wait_quiet();

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
